// ----- rtl/core/dlfr_pkg.sv -----
// Package for the framed-link byte receiver.
// Holds the status codes, configuration indexes, defaults and the config struct.
// No dependencies; every other file of the block imports it.
package dlfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_START = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_BAD_END   = 3'd5
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COMMAND = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_MARKER  = 8'h01;
    localparam logic [BYTE_W-1:0] RST_END_MARKER    = 8'h04;
    localparam logic [BYTE_W-1:0] RST_STATE_COMMAND = 8'h10;

    // Divide by 20 as a shift by two and a multiply by ceil(2^18/5); exact below 2^16.
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int unsigned DIV5_SHIFT = 18;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] state_command;
    } t_cfg;

endpackage

// ----- rtl/core/dlfr_if.sv -----
// Channel interfaces of the framed-link byte receiver: received bytes in, results out.
// Depends on dlfr_pkg for the status type.
interface dlfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlfr_res_if
    import dlfr_pkg::*;
;
    logic       valid;
    logic       ready;
    t_status    status;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [15:0] brightness;
    logic [7:0] wattage;

    modport source (output valid, output status, output frame_cmd, output frame_len,
                    output payload_byte, output payload_valid, output payload_index,
                    output brightness, output wattage, input ready);
    modport sink (input valid, input status, input frame_cmd, input frame_len,
                  input payload_byte, input payload_valid, input payload_index,
                  input brightness, input wattage, output ready);
endinterface

// ----- rtl/core/dimmer_link_frame_receiver.sv -----
// Framed-link byte receiver, top level: configuration registers, input register
// and frame parser. Depends on dlfr_pkg, dlfr_if, dlfr_in_reg and dlfr_core.
//
// Usage:
//   i_rx carries one received byte per transfer; o_res returns exactly one
//   result per byte: status, command and length of the current frame, the
//   payload byte with its position when the byte is payload, and the
//   brightness and wattage latched from the last good state frame.
//   Payload bytes are provisional until a result with status "frame ok".
//   The configuration port writes start marker, end marker and state command
//   (indexes 0, 1, 2) at any edge with i_cfg_we high; write it only while idle.
// Timing:
//   A transferred byte waits in the input register, then its result goes to the
//   output register. One byte per cycle is sustained while results are taken;
//   the parser updates its state as each byte moves between the two registers,
//   and the divide by 20 works off the captured bytes ahead of time.
// Reset:
//   Markers return to 1 and 4, the state command to 16, the parser waits for a
//   start marker, and the latched brightness and wattage read zero.
// Stall:
//   When the result is not taken, the input register still takes a byte if it is
//   empty; after that i_rx.ready stays low until the result is transferred.
module dimmer_link_frame_receiver
    import dlfr_pkg::*;
#(
    parameter int unsigned FRAME_BUFFER_BYTES = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    dlfr_rx_if.sink              i_rx,
    dlfr_res_if.source           o_res
);

    t_cfg              r_cfg;
    logic              w_take;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker  <= RST_START_MARKER;
            r_cfg.end_marker    <= RST_END_MARKER;
            r_cfg.state_command <= RST_STATE_COMMAND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER:  r_cfg.start_marker  <= i_cfg_wdata;
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_wdata;
                CFG_STATE_COMMAND: r_cfg.state_command <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dlfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    dlfr_core #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (w_in_valid),
        .i_in_byte  (w_in_byte),
        .o_take     (w_take),
        .o_res      (o_res)
    );

endmodule

// ----- rtl/core/dlfr_in_reg.sv -----
// Input register of the framed-link receiver: holds one received byte.
// Depends on dlfr_pkg and the dlfr_rx_if interface.
module dlfr_in_reg
    import dlfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlfr_rx_if.sink           i_rx,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    assign i_rx.ready = !r_valid || i_take;
    assign w_load     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- rtl/core/dlfr_core.sv -----
// Frame parser of the framed-link receiver: frame state, checksum, captured
// payload bytes, latched state values and the result register.
// Depends on dlfr_pkg and the dlfr_res_if interface.
module dlfr_core
    import dlfr_pkg::*;
#(
    parameter int unsigned FRAME_BUFFER_BYTES = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_take,
    dlfr_res_if.source        o_res
);

    localparam logic [BYTE_W-1:0] LAST_INDEX = BYTE_W'(FRAME_BUFFER_BYTES - 1);

    logic [BYTE_W-1:0] r_frame_index, n_frame_index;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0] r_sum_hi, n_sum_hi;
    logic [SUM_W-1:0]  r_bright, n_bright;
    logic [BYTE_W-1:0] r_watt, n_watt;
    logic [BYTE_W-1:0] r_cap [4];

    logic              r_out_valid;
    t_status           r_status;
    logic [BYTE_W-1:0] r_pbyte;
    logic              r_pvalid;
    logic [BYTE_W-1:0] r_pindex;

    t_status           w_status;
    logic              w_pvalid;
    logic [BYTE_W-1:0] w_pindex;
    logic [BYTE_W:0]   w_idx9;
    logic [BYTE_W:0]   w_len9;
    logic [SUM_W-1:0]  w_got;
    logic [SUM_W-1:0]  w_power;
    logic [29:0]       w_prod;
    logic [BYTE_W-1:0] w_watt_q;
    logic              w_advance;

    assign w_advance = i_in_valid && (!r_out_valid || o_res.ready);
    assign o_take    = w_advance;

    // Quotient of the captured power word by 20, read from stable registers.
    assign w_power  = {r_cap[3], r_cap[2]};
    assign w_prod   = w_power[SUM_W-1:2] * DIV5_RECIP;
    assign w_watt_q = w_prod[DIV5_SHIFT +: BYTE_W];

    assign w_idx9 = {1'b0, r_frame_index};
    assign w_got  = {r_sum_hi, i_in_byte};

    always_comb begin
        n_frame_index = r_frame_index;
        n_cmd         = r_cmd;
        n_len         = r_len;
        n_sum         = r_sum;
        n_sum_hi      = r_sum_hi;
        n_bright      = r_bright;
        n_watt        = r_watt;
        w_status      = ST_BUSY;
        w_pvalid      = 1'b0;
        w_pindex      = '0;
        w_len9        = {1'b0, r_len};

        if (r_frame_index == '0) begin
            if (i_in_byte != i_cfg.start_marker) begin
                w_status = ST_BAD_START;
            end else begin
                n_sum         = '0;
                n_frame_index = BYTE_W'(1);
            end
        end else if (r_frame_index == LAST_INDEX) begin
            w_status      = ST_OVERFLOW;
            n_frame_index = '0;
        end else begin
            if (r_frame_index == BYTE_W'(2)) begin
                n_cmd = i_in_byte;
            end
            if (r_frame_index == BYTE_W'(3)) begin
                n_len  = i_in_byte;
                w_len9 = {1'b0, i_in_byte};
            end
            // Header and payload bytes feed the checksum.
            if (w_idx9 <= w_len9 + 9'd3) begin
                n_sum = r_sum + SUM_W'(i_in_byte);
                if (r_frame_index >= BYTE_W'(4)) begin
                    w_pvalid = 1'b1;
                    w_pindex = r_frame_index - BYTE_W'(4);
                end
                n_frame_index = r_frame_index + BYTE_W'(1);
            end else if (w_idx9 == w_len9 + 9'd4) begin
                n_sum_hi      = i_in_byte;
                n_frame_index = r_frame_index + BYTE_W'(1);
            end else if (w_idx9 == w_len9 + 9'd5) begin
                if (w_got != r_sum) begin
                    w_status      = ST_BAD_SUM;
                    n_frame_index = '0;
                end else begin
                    n_frame_index = r_frame_index + BYTE_W'(1);
                end
            end else begin
                if (i_in_byte != i_cfg.end_marker) begin
                    w_status = ST_BAD_END;
                end else begin
                    w_status = ST_OK;
                    if (r_cmd == i_cfg.state_command) begin
                        n_bright = {r_cap[1], r_cap[0]};
                        n_watt   = w_watt_q;
                    end
                end
                n_frame_index = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_index <= '0;
            r_cmd         <= '0;
            r_len         <= '0;
            r_sum         <= '0;
            r_sum_hi      <= '0;
            r_bright      <= '0;
            r_watt        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_frame_index <= n_frame_index;
                r_cmd         <= n_cmd;
                r_len         <= n_len;
                r_sum         <= n_sum;
                r_sum_hi      <= n_sum_hi;
                r_bright      <= n_bright;
                r_watt        <= n_watt;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured payload positions 2, 3, 6 and 7; also written in frames later dropped.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_pvalid) begin
            case (w_pindex)
                BYTE_W'(2): r_cap[0] <= i_in_byte;
                BYTE_W'(3): r_cap[1] <= i_in_byte;
                BYTE_W'(6): r_cap[2] <= i_in_byte;
                BYTE_W'(7): r_cap[3] <= i_in_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_status <= w_status;
            r_pvalid <= w_pvalid;
            r_pindex <= w_pindex;
            r_pbyte  <= w_pvalid ? i_in_byte : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.frame_cmd     = r_cmd;
    assign o_res.frame_len     = r_len;
    assign o_res.payload_byte  = r_pbyte;
    assign o_res.payload_valid = r_pvalid;
    assign o_res.payload_index = r_pindex;
    assign o_res.brightness    = r_bright;
    assign o_res.wattage       = r_watt;

    a_index_in_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_index <= LAST_INDEX)
        else $error("frame index beyond buffer limit");

    a_payload_only_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_pvalid |-> r_status == ST_BUSY)
        else $error("payload byte reported with a final status");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_frame_index) && $stable(r_sum))
        else $error("frame state moved without a transfer");

    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("transfer produced no result");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the framed-link byte receiver: random and directed byte streams
// are checked against an in-bench frame parser, one result per received byte.
// Depends on dlfr_pkg, dlfr_if and the dimmer_link_frame_receiver RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlfr_pkg::*;

    localparam int unsigned RX_BUF_BYTES = 255;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned MAX_PRINTED  = 40;

    typedef struct packed {
        t_status     status;
        logic [7:0]  frame_cmd;
        logic [7:0]  frame_len;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [7:0]  payload_index;
        logic [15:0] brightness;
        logic [7:0]  wattage;
    } t_rx_result;

    typedef enum {END_GOOD, END_BAD_SUM, END_BAD_MARK} t_frame_end;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_wdata;

    dlfr_rx_if  rx_ch ();
    dlfr_res_if res_ch ();

    dimmer_link_frame_receiver #(
        .FRAME_BUFFER_BYTES(RX_BUF_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    // Shadow of the configuration registers.
    logic [7:0] cfg_start;
    logic [7:0] cfg_end;
    logic [7:0] cfg_state_cmd;

    // Shadow of the frame parser.
    logic [7:0]  fr_index;
    logic [7:0]  fr_cmd;
    logic [7:0]  fr_len;
    logic [15:0] fr_sum;
    logic [7:0]  fr_sum_hi;
    logic [7:0]  fr_capture [4];
    logic [15:0] fr_brightness;
    logic [7:0]  fr_wattage;

    logic [7:0] rx_pending [$];
    t_rx_result predicted_results [$];
    logic [7:0] payload_buf [256];

    int unsigned queued_bytes;
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned quiet_cycles;
    bit          rx_taken;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                     result_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b, output t_rx_result r);
        int unsigned ix;
        int unsigned ln;
        int unsigned power;
        r = '0;
        r.status = ST_BUSY;
        ix = fr_index;
        ln = fr_len;
        if (ix == 0) begin
            if (b != cfg_start) begin
                r.status = ST_BAD_START;
            end else begin
                fr_sum = '0;
                fr_index = 8'd1;
            end
        end else if (ix == RX_BUF_BYTES - 1) begin
            r.status = ST_OVERFLOW;
            fr_index = '0;
        end else begin
            if (ix == 2) fr_cmd = b;
            if (ix == 3) begin
                fr_len = b;
                ln = b;
            end
            if (ix <= 3 + ln) begin
                fr_sum = fr_sum + 16'(b);
                if (ix >= 4) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    r.payload_index = 8'(ix - 4);
                    case (ix - 4)
                        2: fr_capture[0] = b;
                        3: fr_capture[1] = b;
                        6: fr_capture[2] = b;
                        7: fr_capture[3] = b;
                        default: ;
                    endcase
                end
                fr_index = 8'(ix + 1);
            end else if (ix == 4 + ln) begin
                fr_sum_hi = b;
                fr_index = 8'(ix + 1);
            end else if (ix == 5 + ln) begin
                if ({fr_sum_hi, b} != fr_sum) begin
                    r.status = ST_BAD_SUM;
                    fr_index = '0;
                end else begin
                    fr_index = 8'(ix + 1);
                end
            end else begin
                if (b != cfg_end) begin
                    r.status = ST_BAD_END;
                end else begin
                    r.status = ST_OK;
                    if (fr_cmd == cfg_state_cmd) begin
                        power = {fr_capture[3], fr_capture[2]};
                        power = power / 20;
                        fr_brightness = {fr_capture[1], fr_capture[0]};
                        fr_wattage = power[7:0];
                    end
                end
                fr_index = '0;
            end
        end
        r.frame_cmd = fr_cmd;
        r.frame_len = fr_len;
        r.brightness = fr_brightness;
        r.wattage = fr_wattage;
    endtask

    task automatic push_rx(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    // Frame built from payload_buf[0:len-1] under the current markers.
    task automatic push_frame(input logic [7:0] cmd, input int unsigned len,
                              input t_frame_end how);
        logic [15:0] sum;
        logic [7:0]  seq;
        logic [7:0]  tail;
        seq = 8'($urandom_range(0, 255));
        sum = 16'(seq) + 16'(cmd) + 16'(len[7:0]);
        push_rx(cfg_start);
        push_rx(seq);
        push_rx(cmd);
        push_rx(len[7:0]);
        for (int i = 0; i < len; i++) begin
            push_rx(payload_buf[i]);
            sum = sum + 16'(payload_buf[i]);
        end
        if (how == END_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        push_rx(sum[15:8]);
        push_rx(sum[7:0]);
        if (how == END_GOOD) begin
            push_rx(cfg_end);
        end else if (how == END_BAD_MARK) begin
            do tail = 8'($urandom_range(0, 255)); while (tail == cfg_end);
            push_rx(tail);
        end
    endtask

    // A length that makes the frame longer than the buffer makes the parser run into its index limit.
    task automatic push_overflow_frame();
        push_rx(cfg_start);
        push_rx(8'($urandom_range(0, 255)));
        push_rx(8'($urandom_range(0, 255)));
        push_rx(8'($urandom_range(249, 255)));
        for (int i = 0; i < RX_BUF_BYTES - 4; i++) push_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic push_random_traffic(input int unsigned budget, input bit with_overflow);
        int unsigned pick;
        int unsigned len;
        int unsigned ovf_at;
        logic [7:0]  cmd;
        logic [7:0]  junk;
        t_frame_end  how;
        ovf_at = $urandom_range(0, budget - 1);
        queued_bytes = 0;
        while (queued_bytes < budget) begin
            if (with_overflow && queued_bytes >= ovf_at) begin
                push_overflow_frame();
                with_overflow = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    do junk = 8'($urandom_range(0, 255)); while (junk == cfg_start);
                    push_rx(junk);
                end
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 247)
                                                   : $urandom_range(0, 12);
                cmd = $urandom_range(0, 1) ? cfg_state_cmd : 8'($urandom_range(0, 255));
                how = (pick < 16) ? END_BAD_SUM : (pick < 24) ? END_BAD_MARK : END_GOOD;
                for (int i = 0; i < len; i++) payload_buf[i] = 8'($urandom_range(0, 255));
                push_frame(cmd, len, how);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_START_MARKER:  cfg_start = val;
            CFG_END_MARKER:    cfg_end = val;
            CFG_STATE_COMMAND: cfg_state_cmd = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || predicted_results.size() != 0 || rx_ch.valid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_idle_mode(input int unsigned mode);
        case (mode)
            0: begin
                src_idle_pct = 27;
                snk_idle_pct = 63;
            end
            1: begin
                src_idle_pct = 63;
                snk_idle_pct = 27;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // Sender side: a new byte is offered only once the previous one was transferred; result ready is random.
    always @(negedge i_clk) begin : driver
        logic       nv;
        logic [7:0] nb;
        if (!rx_ch.valid || rx_taken) begin
            nb = rx_ch.rx_byte;
            nv = 1'b0;
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nv = 1'b1;
                nb = rx_pending.pop_front();
            end
            rx_ch.valid <= nv;
            rx_ch.rx_byte <= nb;
        end
        rx_taken = 1'b0;
        res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_rx_result want;
        t_rx_result got;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                rx_taken = 1'b1;
                parse_rx_byte(rx_ch.rx_byte, want);
                predicted_results.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                result_count++;
                got.status = res_ch.status;
                got.frame_cmd = res_ch.frame_cmd;
                got.frame_len = res_ch.frame_len;
                got.payload_byte = res_ch.payload_byte;
                got.payload_valid = res_ch.payload_valid;
                got.payload_index = res_ch.payload_index;
                got.brightness = res_ch.brightness;
                got.wattage = res_ch.wattage;
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with none pending, status", 16'(got.status), '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 16'(got.status), 16'(want.status));
                    if (got.frame_cmd !== want.frame_cmd)
                        report_mismatch("frame_cmd", 16'(got.frame_cmd), 16'(want.frame_cmd));
                    if (got.frame_len !== want.frame_len)
                        report_mismatch("frame_len", 16'(got.frame_len), 16'(want.frame_len));
                    if (got.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", 16'(got.payload_byte),
                                        16'(want.payload_byte));
                    if (got.payload_valid !== want.payload_valid)
                        report_mismatch("payload_valid", 16'(got.payload_valid),
                                        16'(want.payload_valid));
                    if (got.payload_index !== want.payload_index)
                        report_mismatch("payload_index", 16'(got.payload_index),
                                        16'(want.payload_index));
                    if (got.brightness !== want.brightness)
                        report_mismatch("brightness", got.brightness, want.brightness);
                    if (got.wattage !== want.wattage)
                        report_mismatch("wattage", 16'(got.wattage), 16'(want.wattage));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] s_mark;
        logic [7:0] e_mark;
        logic [7:0] st_cmd;
        int unsigned budget;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_START_MARKER;
        i_cfg_wdata = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        rx_taken = 1'b0;
        quiet_cycles = 0;
        mismatch_count = 0;
        result_count = 0;
        cfg_start = RST_START_MARKER;
        cfg_end = RST_END_MARKER;
        cfg_state_cmd = RST_STATE_COMMAND;
        fr_index = '0;
        fr_cmd = '0;
        fr_len = '0;
        fr_sum = '0;
        fr_sum_hi = '0;
        fr_brightness = '0;
        fr_wattage = '0;
        for (int i = 0; i < 4; i++) fr_capture[i] = '0;
        set_idle_mode(0);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The opening frame is a state frame long enough to reach every captured payload
        // position, so each holds a value before any shorter state frame can end well.
        payload_buf[0] = 8'h00;
        payload_buf[1] = 8'hFF;
        payload_buf[2] = 8'hFF;
        payload_buf[3] = 8'hFF;
        payload_buf[4] = 8'hAA;
        payload_buf[5] = 8'h55;
        payload_buf[6] = 8'hFF;
        payload_buf[7] = 8'hFF;
        push_frame(RST_STATE_COMMAND, 8, END_GOOD);
        push_rx(8'h00);
        push_rx(8'hFF);
        push_frame(RST_STATE_COMMAND, 0, END_BAD_SUM);
        push_frame(8'hFF, 0, END_BAD_MARK);
        wait_drained();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: begin
                    s_mark = 8'h00;
                    e_mark = 8'hFF;
                    st_cmd = 8'h00;
                end
                2: begin
                    s_mark = 8'hFF;
                    e_mark = 8'h00;
                    st_cmd = 8'hFF;
                end
                default: begin
                    s_mark = 8'($urandom_range(0, 255));
                    e_mark = 8'($urandom_range(0, 255));
                    st_cmd = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_START_MARKER, s_mark);
            write_reg(CFG_END_MARKER, e_mark);
            write_reg(CFG_STATE_COMMAND, st_cmd);
            set_idle_mode((ph - 1) % 3);
            budget = (ph == 2 || ph == 5) ? 170 : 260;
            push_random_traffic(budget, ph == 2 || ph == 5);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dlfr_pkg.sv
rtl/core/dlfr_if.sv
rtl/core/dlfr_in_reg.sv
rtl/core/dlfr_core.sv
rtl/core/dimmer_link_frame_receiver.sv
bench/tb_top.sv
